// ===== hdl/pts_pkg.sv =====
// Package with the field widths, action codes and shared types of the task scheduler.
`default_nettype none
package pts_pkg;

  localparam int SLOT_W   = 3;
  localparam int PERIOD_W = 16;

  localparam int TASK_COUNT_DEF    = 8;
  localparam int COUNT_WIDTH_DEF   = 16;
  localparam int PENDING_WIDTH_DEF = 8;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_DISPATCH = 2'd1,
    ACT_INSTALL  = 2'd2
  } action_t;

  typedef struct packed {
    logic [1:0]          action;
    logic [SLOT_W-1:0]   slot;
    logic [PERIOD_W-1:0] period;
    logic                enable;
  } cmd_item_t;

  typedef struct packed {
    logic              dispatched;
    logic [SLOT_W-1:0] task_slot;
  } result_item_t;

  // Decoded command broadcast to every cell.
  typedef struct packed {
    logic              tick;
    logic              dispatch;
    logic              install;
    logic              enable;
    logic [SLOT_W-1:0] slot;
  } cell_cmd_t;

  // Priority link handed from one cell to the next.
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } chain_t;

endpackage
`default_nettype wire

// ===== hdl/pts_cmd_if.sv =====
// Valid/ready channel carrying scheduler command items.
`default_nettype none
interface pts_cmd_if import pts_pkg::*; ();
  logic      valid;
  logic      ready;
  cmd_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/pts_result_if.sv =====
// Valid/ready channel carrying scheduler result items.
`default_nettype none
interface pts_result_if import pts_pkg::*; ();
  logic         valid;
  logic         ready;
  result_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/periodic_task_scheduler.sv =====
// Top level of the periodic task scheduler: command decode, row of slot cells, result register.
//
//   Port    Direction  Carries
//   cmd     sink       action, slot, period, enable
//   result  source     dispatched, task_slot
//
// One command is taken per cycle; its result is registered and offered the cycle after.
// The priority search ripples through the row of cells within that cycle.
// A new command is taken while the result register is empty or being emptied.
// A stalled result holds, and the command channel stalls behind it.
// Synchronous reset clears every slot.
`default_nettype none
module periodic_task_scheduler import pts_pkg::*; #(
  parameter int TASK_COUNT    = TASK_COUNT_DEF,
  parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF,
  parameter int PENDING_WIDTH = PENDING_WIDTH_DEF
) (
  input wire logic     clk,
  input wire logic     rst,
  pts_cmd_if.sink      cmd,
  pts_result_if.source result
);

  cell_cmd_t              cell_cmd;
  logic [COUNT_WIDTH-1:0] period_cw;
  chain_t                 link [TASK_COUNT+1];
  logic                   take;

  logic         out_valid;
  result_item_t out_data;

  assign cmd.ready    = !out_valid || result.ready;
  assign take         = cmd.valid && cmd.ready;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  assign period_cw = COUNT_WIDTH'(cmd.data.period);

  always_comb begin
    cell_cmd        = '0;
    cell_cmd.enable = cmd.data.enable;
    cell_cmd.slot   = cmd.data.slot;
    unique case (cmd.data.action)
      ACT_TICK:     cell_cmd.tick     = take;
      ACT_DISPATCH: cell_cmd.dispatch = take;
      ACT_INSTALL:  cell_cmd.install  = take;
      default:      ;
    endcase
  end

  assign link[0] = '0;

  for (genvar i = 0; i < TASK_COUNT; i++) begin : g_cell
    pts_cell #(
      .INDEX         (i),
      .COUNT_WIDTH   (COUNT_WIDTH),
      .PENDING_WIDTH (PENDING_WIDTH)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .cmd    (cell_cmd),
      .period (period_cw),
      .up     (link[i]),
      .down   (link[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (cmd.data.action == ACT_DISPATCH && link[TASK_COUNT].found) begin
        out_data.dispatched <= 1'b1;
        out_data.task_slot  <= link[TASK_COUNT].slot;
      end else begin
        out_data <= '0;
      end
    end
  end

  a_take_gives_result: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("accepted command did not load the result register");

  a_pending_is_dispatched: assert property (@(posedge clk) disable iff (rst)
    take && cmd.data.action == ACT_DISPATCH && link[TASK_COUNT].found
      |=> out_data.dispatched)
    else $error("dispatch with pending runs reported nothing");

  a_only_dispatch_reports: assert property (@(posedge clk) disable iff (rst)
    take && cmd.data.action != ACT_DISPATCH |=> !out_data.dispatched)
    else $error("non-dispatch command reported a dispatched slot");

  a_idle_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.dispatched |-> out_data.task_slot == '0)
    else $error("slot field not zero on an empty result");

endmodule
`default_nettype wire

// ===== hdl/pts_cell.sv =====
// One task slot: enable, period, countdown and pending count, plus its link in the priority chain.
`default_nettype none
module pts_cell import pts_pkg::*; #(
  parameter int INDEX         = 0,
  parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF,
  parameter int PENDING_WIDTH = PENDING_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cell_cmd_t              cmd,
  input  wire logic [COUNT_WIDTH-1:0] period,
  input  wire chain_t                 up,
  output chain_t                      down
);

  localparam logic [SLOT_W-1:0] CELL_ID     = SLOT_W'(INDEX);
  localparam bit                ADDRESSABLE = (INDEX < (1 << SLOT_W));

  logic                     enabled;
  logic [COUNT_WIDTH-1:0]   reload;
  logic [COUNT_WIDTH-1:0]   countdown;
  logic [PENDING_WIDTH-1:0] pending;

  logic has_pending;
  logic chosen;
  logic selected;

  assign has_pending = (pending != '0);
  // A cell is chosen when it has runs waiting and no lower slot has claimed the transfer.
  assign chosen      = has_pending && !up.found;
  assign selected    = ADDRESSABLE && (cmd.slot == CELL_ID);

  assign down.found = up.found || has_pending;
  assign down.slot  = up.found ? up.slot : CELL_ID;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled   <= 1'b0;
      reload    <= '0;
      countdown <= '0;
      pending   <= '0;
    end else if (cmd.install && selected) begin
      enabled   <= cmd.enable;
      reload    <= period;
      countdown <= period;
      pending   <= '0;
    end else if (cmd.tick && enabled) begin
      countdown <= countdown - COUNT_WIDTH'(1);
      if (countdown == COUNT_WIDTH'(1) && pending != '1) begin
        pending <= pending + PENDING_WIDTH'(1);
      end
    end else if (cmd.dispatch && chosen) begin
      pending   <= pending - PENDING_WIDTH'(1);
      countdown <= reload;
    end
  end

endmodule
`default_nettype wire
